/* design/modbus_rtu_read_response_parser_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Modbus RTU response parser
// Same-cycle and next-cycle implication checks on the parser clock.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_READ_RESPONSE_PARSER_ASSERT_SVH
`define MODBUS_RTU_READ_RESPONSE_PARSER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MBRTU_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("modbus parser: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define MBRTU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("modbus parser: next-cycle check failed");

`endif

/* design/mbrtu_pkg.sv */
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Types and constants shared by the Modbus RTU response parser modules.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

   typedef enum logic [6:0] {
      PH_IDLE    = 7'b0000001,
      PH_FUNC    = 7'b0000010,
      PH_COUNT   = 7'b0000100,
      PH_PAYLOAD = 7'b0001000,
      PH_CRC_LO  = 7'b0010000,
      PH_CRC_HI  = 7'b0100000,
      PH_REJECT  = 7'b1000000
   } phase_type;

   typedef enum logic [2:0] {
      CTL_READY   = 3'b001,
      CTL_HDR_ERR = 3'b010,
      CTL_EMIT    = 3'b100
   } ctl_type;

   typedef struct packed {
      logic init;     // restart from the initial value with this byte
      logic advance;  // fold this byte into the running value
   } crc_ctrl_type;

   localparam logic [1:0] STATUS_VALUE  = 2'd0;
   localparam logic [1:0] STATUS_HEADER = 2'd1;
   localparam logic [1:0] STATUS_CRC    = 2'd2;
   localparam logic [1:0] STATUS_CUT    = 2'd3;

   localparam logic [0:0] CSR_SLAVE_ADDRESS  = 1'b0;
   localparam logic [0:0] CSR_REGISTER_COUNT = 1'b1;

   localparam logic [7:0]  SLAVE_ADDRESS_RST  = 8'd80;
   localparam logic [3:0]  REGISTER_COUNT_RST = 4'd12;
   localparam logic [7:0]  FUNC_READ_HOLDING  = 8'h03;
   localparam logic [15:0] CRC_INIT           = 16'hFFFF;
   localparam logic [15:0] CRC_POLY           = 16'hA001;

endpackage

/* design/mbrtu_crc.sv */
// ----------------------------------------------------------------------------
// mbrtu_crc
// CRC-16/Modbus accumulator, one byte per cycle, reflected polynomial.
// ----------------------------------------------------------------------------
module mbrtu_crc
   import mbrtu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  crc_ctrl_type ctrl,
   input  logic [7:0]   data,
   output logic [15:0]  crc
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] x;
      x = c ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
      end
      return x;
   endfunction

   always_comb begin
      crc_in = crc_ff;
      if (ctrl.init) begin
         crc_in = crc_byte(CRC_INIT, data);
      end else if (ctrl.advance) begin
         crc_in = crc_byte(crc_ff, data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_ff;

endmodule

/* design/modbus_rtu_read_response_parser.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_read_response_parser
// Checks a read-holding-registers response byte by byte and reads out the
// stored register words once the CRC trailer matches.
// Throughput: one byte per cycle while busy is low; busy stays low while bytes are parsed.
// A trailer match reads the register store through its single read port:
// each word is read in the emit state and registered, one per cycle, busy high.
// A cut-short frame that also fails the address gives two results, header error last.
// Synchronous reset: parser idle, CRC all ones, config at its reset values.
// ----------------------------------------------------------------------------
`include "modbus_rtu_read_response_parser_assert.svh"

module modbus_rtu_read_response_parser
   import mbrtu_pkg::*;
#(
   parameter int MAX_REGS = 12
)
(
   input  logic               clock,
   input  logic               reset,
   // byte input
   input  logic               start,
   output logic               busy,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_frame_start,
   // results
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [3:0]         rsp_reg_index,
   output logic signed [15:0] rsp_reg_value,
   output logic               rsp_last,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [0:0]         csr_index,
   input  logic [7:0]         csr_wdata
);

   localparam int IDXW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

   logic [7:0]  slave_addr_ff;
   logic [3:0]  reg_count_ff;

   phase_type   phase_ff, phase_in;
   ctl_type     ctl_ff, ctl_in;
   logic [4:0]  pos_ff, pos_in;
   logic [3:0]  frame_regs_ff, frame_regs_in;
   logic [3:0]  emit_idx_ff, emit_idx_in;
   logic [7:0]  high_hold_ff;
   logic [7:0]  crc_lo_ff;
   logic        high_hold_we, crc_lo_we;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [3:0]  rsp_index_ff, rsp_index_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_mem_ff, rsp_mem_in;

   logic [15:0]     reg_store_ff [MAX_REGS];
   logic [15:0]     mem_q_ff;
   logic            mem_we, mem_re;
   logic [IDXW-1:0] mem_waddr, mem_raddr;

   crc_ctrl_type crc_ctrl;
   logic [15:0]  crc_value;

   logic        cut_short, addr_ok, count_ok, word_ok, emit_last;
   logic [4:0]  pos_next;

   mbrtu_crc u_crc (
      .clock (clock),
      .reset (reset),
      .ctrl  (crc_ctrl),
      .data  (req_rx_byte),
      .crc   (crc_value)
   );

   assign busy      = (ctl_ff != CTL_READY);
   assign csr_ready = 1'b1;

   assign cut_short = (phase_ff != PH_IDLE) && (phase_ff != PH_REJECT);
   assign addr_ok   = (req_rx_byte == slave_addr_ff);
   assign count_ok  = (reg_count_ff != 4'd0) && (32'(reg_count_ff) <= 32'(MAX_REGS))
                      && (req_rx_byte == {3'b000, reg_count_ff, 1'b0});
   assign word_ok   = (32'(pos_ff[4:1]) < 32'(MAX_REGS));
   assign pos_next  = pos_ff + 5'd1;
   assign emit_last = (emit_idx_ff == (frame_regs_ff - 4'd1));
   assign mem_waddr = IDXW'(pos_ff[4:1]);
   assign mem_raddr = IDXW'(emit_idx_ff);

   always_comb begin
      phase_in      = phase_ff;
      ctl_in        = ctl_ff;
      pos_in        = pos_ff;
      frame_regs_in = frame_regs_ff;
      emit_idx_in   = emit_idx_ff;
      high_hold_we  = 1'b0;
      crc_lo_we     = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      crc_ctrl      = '0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_VALUE;
      rsp_index_in  = 4'd0;
      rsp_last_in   = 1'b0;
      rsp_mem_in    = 1'b0;

      unique case (ctl_ff)
         CTL_READY: begin
            if (start) begin
               if (req_frame_start) begin
                  crc_ctrl.init = 1'b1;
                  pos_in        = 5'd0;
                  phase_in      = addr_ok ? PH_FUNC : PH_REJECT;
                  if (cut_short) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_CUT;
                     rsp_last_in   = addr_ok;
                     // header error goes out from the CTL_HDR_ERR state, after the cut-short result
                     if (!addr_ok) ctl_in = CTL_HDR_ERR;
                  end else if (!addr_ok) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_HEADER;
                     rsp_last_in   = 1'b1;
                  end
               end else begin
                  unique case (phase_ff)
                     PH_FUNC: begin
                        crc_ctrl.advance = 1'b1;
                        if (req_rx_byte == FUNC_READ_HOLDING) begin
                           phase_in = PH_COUNT;
                        end else begin
                           phase_in      = PH_REJECT;
                           rsp_valid_in  = 1'b1;
                           rsp_status_in = STATUS_HEADER;
                           rsp_last_in   = 1'b1;
                        end
                     end
                     PH_COUNT: begin
                        crc_ctrl.advance = 1'b1;
                        if (count_ok) begin
                           frame_regs_in = reg_count_ff;
                           pos_in        = 5'd0;
                           phase_in      = PH_PAYLOAD;
                        end else begin
                           phase_in      = PH_REJECT;
                           rsp_valid_in  = 1'b1;
                           rsp_status_in = STATUS_HEADER;
                           rsp_last_in   = 1'b1;
                        end
                     end
                     PH_PAYLOAD: begin
                        crc_ctrl.advance = 1'b1;
                        if (!pos_ff[0]) begin
                           high_hold_we = 1'b1;
                        end else if (word_ok) begin
                           mem_we = 1'b1;
                        end
                        pos_in = pos_next;
                        if (pos_next >= {frame_regs_ff, 1'b0}) phase_in = PH_CRC_LO;
                     end
                     PH_CRC_LO: begin
                        crc_lo_we = 1'b1;
                        phase_in  = PH_CRC_HI;
                     end
                     PH_CRC_HI: begin
                        phase_in = PH_IDLE;
                        if ({req_rx_byte, crc_lo_ff} == crc_value) begin
                           ctl_in      = CTL_EMIT;
                           emit_idx_in = 4'd0;
                        end else begin
                           rsp_valid_in  = 1'b1;
                           rsp_status_in = STATUS_CRC;
                           rsp_last_in   = 1'b1;
                        end
                     end
                     PH_IDLE, PH_REJECT: begin
                     end
                     default: phase_in = PH_IDLE;
                  endcase
               end
            end
         end
         CTL_HDR_ERR: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_HEADER;
            rsp_last_in   = 1'b1;
            ctl_in        = CTL_READY;
         end
         CTL_EMIT: begin
            // read one stored word per cycle; data lands with the strobe
            mem_re        = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_VALUE;
            rsp_index_in  = emit_idx_ff;
            rsp_mem_in    = 1'b1;
            rsp_last_in   = emit_last;
            emit_idx_in   = emit_idx_ff + 4'd1;
            if (emit_last) ctl_in = CTL_READY;
         end
         default: ctl_in = CTL_READY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= SLAVE_ADDRESS_RST;
         reg_count_ff  <= REGISTER_COUNT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SLAVE_ADDRESS:  slave_addr_ff <= csr_wdata;
            CSR_REGISTER_COUNT: reg_count_ff  <= csr_wdata[3:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         ctl_ff        <= CTL_READY;
         pos_ff        <= 5'd0;
         frame_regs_ff <= 4'd0;
         emit_idx_ff   <= 4'd0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= STATUS_VALUE;
         rsp_index_ff  <= 4'd0;
         rsp_last_ff   <= 1'b0;
         rsp_mem_ff    <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         ctl_ff        <= ctl_in;
         pos_ff        <= pos_in;
         frame_regs_ff <= frame_regs_in;
         emit_idx_ff   <= emit_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_mem_ff    <= rsp_mem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (high_hold_we) high_hold_ff <= req_rx_byte;
      if (crc_lo_we)    crc_lo_ff    <= req_rx_byte;
   end

   // register store: written during the payload, read only after the trailer
   always_ff @(posedge clock) begin
      if (mem_we) reg_store_ff[mem_waddr] <= {high_hold_ff, req_rx_byte};
      if (mem_re) mem_q_ff <= reg_store_ff[mem_raddr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_reg_index = rsp_index_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_reg_value = rsp_mem_ff ? signed'(mem_q_ff) : 16'sd0;

   `MBRTU_ASSERT_NEXT(a_hdr_err_follows, ctl_ff == CTL_HDR_ERR, rsp_valid && rsp_last && rsp_status == STATUS_HEADER)
   `MBRTU_ASSERT_NEXT(a_emit_strobes, ctl_ff == CTL_EMIT, rsp_valid && rsp_status == STATUS_VALUE)
   `MBRTU_ASSERT_SAME(a_err_zero, rsp_valid && rsp_status != STATUS_VALUE, rsp_reg_value == 16'sd0 && rsp_reg_index == 4'd0)
   `MBRTU_ASSERT_SAME(a_more_busy, rsp_valid && !rsp_last, busy)

endmodule
